### rtl/core/gs3_pkg.sv
// Shared widths and sideband types for the 3x3 Gram-Schmidt pipeline.
// No dependencies; used by the channel interfaces, the divider and the top level.
package gs3_pkg;

  localparam int A_W     = 16;  // input component, Q7.8
  localparam int OUT_W   = 32;  // result component, Q15.16
  localparam int Q_W     = 25;  // quotient magnitude bits (bound is 256*|u| < 2^24)
  localparam int DEN1_W  = 32;  // a.a
  localparam int NUM1_W  = 56;  // |a.u| * |a_i| * 256
  localparam int V2_W    = 26;  // v2 component and c*256 - proj_a(c)
  localparam int DEN2_W  = 52;  // v2.v2
  localparam int VC_W    = 43;  // v2.c, signed
  localparam int NUM2_W  = 75;  // |v2.c| * |v2_i| * 256

  // carried alongside the first divider
  typedef struct packed {
    logic [2:0][A_W-1:0] a;
    logic [2:0][A_W-1:0] b;
    logic [2:0][A_W-1:0] c;
    logic                degen;
  } gs3_side_a_t;

  // carried alongside the second divider
  typedef struct packed {
    logic [2:0][A_W-1:0]  a;
    logic [2:0][V2_W-1:0] v2;
    logic [2:0][V2_W-1:0] t;
    logic                 degen;
  } gs3_side_b_t;

endpackage

### rtl/core/gs3_in_if.sv
// Request channel carrying the three input vectors a, b and c.
// Depends on gs3_pkg for the component width.
interface gs3_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [gs3_pkg::A_W-1:0]  a_x, a_y, a_z;
  logic signed [gs3_pkg::A_W-1:0]  b_x, b_y, b_z;
  logic signed [gs3_pkg::A_W-1:0]  c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

### rtl/core/gs3_out_if.sv
// Result channel carrying the orthogonal set v1, v2, v3 and the degenerate flag.
// Depends on gs3_pkg for the component width.
interface gs3_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gs3_pkg::OUT_W-1:0]  first_x, first_y, first_z;
  logic signed [gs3_pkg::OUT_W-1:0]  second_x, second_y, second_z;
  logic signed [gs3_pkg::OUT_W-1:0]  third_x, third_y, third_z;
  logic                              degenerate;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, degenerate, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                third_x, third_y, third_z, degenerate, output ready);
endinterface

### rtl/core/gs3_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing
// one divisor, with a sideband word carried along. Depends on gs3_pkg.
module gs3_div_pipe #(
  parameter int LANES = 3,
  parameter int NW    = gs3_pkg::NUM1_W,
  parameter int DW    = gs3_pkg::DEN1_W,
  parameter int QW    = gs3_pkg::Q_W,
  parameter int SW    = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [NW-1:0]       in_num [LANES],
  input  logic [LANES-1:0]    in_neg,
  input  logic [DW-1:0]       in_den,
  input  logic [SW-1:0]       in_side,
  output logic                out_vld,
  output logic signed [QW:0]  out_quot [LANES],
  output logic [SW-1:0]       out_side
);

  // caller guarantees num < den * 2^QW, so the remainder always fits DW bits
  logic [DW-1:0]    rem_r  [QW][LANES];
  logic [QW-1:0]    lo_r   [QW][LANES];
  logic [QW-1:0]    q_r    [QW][LANES];
  logic [LANES-1:0] neg_r  [QW];
  logic [DW-1:0]    den_r  [QW];
  logic [SW-1:0]    side_r [QW];
  logic [QW-1:0]    vld_r;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0]    rem_p   [LANES];
    logic [QW-1:0]    lo_p    [LANES];
    logic [QW-1:0]    q_p     [LANES];
    logic [LANES-1:0] neg_p;
    logic [DW-1:0]    den_p;
    logic [SW-1:0]    side_p;
    logic             vld_p;
    logic [DW:0]      trial   [LANES];
    logic [DW-1:0]    rem_nxt [LANES];
    logic [QW-1:0]    q_nxt   [LANES];

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_p[l] = DW'(in_num[l] >> QW);
          lo_p[l]  = in_num[l][QW-1:0];
          q_p[l]   = '0;
        end
        neg_p  = in_neg;
        den_p  = in_den;
        side_p = in_side;
        vld_p  = in_vld;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_p[l] = rem_r[s-1][l];
          lo_p[l]  = lo_r[s-1][l];
          q_p[l]   = q_r[s-1][l];
        end
        neg_p  = neg_r[s-1];
        den_p  = den_r[s-1];
        side_p = side_r[s-1];
        vld_p  = vld_r[s-1];
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_p[l], lo_p[l][QW-1]};
        if (trial[l] >= {1'b0, den_p}) begin
          rem_nxt[l] = DW'(trial[l] - {1'b0, den_p});
          q_nxt[l]   = {q_p[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[l][DW-1:0];
          q_nxt[l]   = {q_p[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          lo_r[s][l]  <= {lo_p[l][QW-2:0], 1'b0};
          q_r[s][l]   <= q_nxt[l];
        end
        neg_r[s]  <= neg_p;
        den_r[s]  <= den_p;
        side_r[s] <= side_p;
      end
    end
  end

  // zero divisor: projection skipped, quotient forced to zero
  logic [QW:0] q_ext [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_ext[l] = {1'b0, q_r[QW-1][l]};
      if (den_r[QW-1] == '0) begin
        out_quot[l] = '0;
      end else if (neg_r[QW-1][l]) begin
        out_quot[l] = $signed(-q_ext[l]);
      end else begin
        out_quot[l] = $signed(q_ext[l]);
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_side = side_r[QW-1];

  for (genvar l = 0; l < LANES; l++) begin : g_chk
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
      (vld_r[QW-1] && den_r[QW-1] != '0) |-> (rem_r[QW-1][l] < den_r[QW-1]))
      else $error("divider remainder not below divisor, quotient overflowed");

    a_zero_den_quot: assert property (@(posedge clk) disable iff (!rst_n)
      (vld_r[QW-1] && den_r[QW-1] == '0) |-> (out_quot[l] == '0))
      else $error("nonzero quotient for a zero divisor");
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("divider pipeline moved while stalled");

endmodule

### rtl/core/gram_schmidt_orthogonalize_3x3.sv
// Top level: classical Gram-Schmidt on three 3-vectors, Q7.8 in, Q15.16 out.
// Depends on gs3_pkg, gs3_in_if, gs3_out_if and gs3_div_pipe.
//
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    a_x..c_z, 16-bit signed Q7.8
//  out_chan  out  valid/ready    first_*..third_* 32-bit Q15.16, degenerate
//
// One request per cycle unless the pipe holds (see below). Pipe: 3 dot/numerator stages, 25 divider
// stages (projections on a), 4 stages for v2 and its dots, 25 divider stages
// (projection on v2), 1 output stage. The bit-per-stage dividers set the depth.
// Reset (synchronous, active low) clears only the valid bits.
// The whole pipe advances together; it holds when the output register is full
// and not taken, so in_chan.ready follows out_chan.ready combinationally.
module gram_schmidt_orthogonalize_3x3 (
  input  logic       clk,
  input  logic       rst_n,
  gs3_in_if.sink     in_chan,
  gs3_out_if.source  out_chan
);

  localparam int A_W  = gs3_pkg::A_W;
  localparam int Q_W  = gs3_pkg::Q_W;
  localparam int V2_W = gs3_pkg::V2_W;

  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  // ---------------- stage 1: elementwise products ----------------
  logic signed [A_W-1:0] a_in [3], b_in [3], c_in [3];
  assign a_in = '{in_chan.a_x, in_chan.a_y, in_chan.a_z};
  assign b_in = '{in_chan.b_x, in_chan.b_y, in_chan.b_z};
  assign c_in = '{in_chan.c_x, in_chan.c_y, in_chan.c_z};

  logic signed [A_W-1:0] a1_r [3], b1_r [3], c1_r [3];
  logic signed [31:0]    paa_nxt [3], pab_nxt [3], pac_nxt [3];
  logic [30:0]           paa1_r [3];
  logic signed [31:0]    pab1_r [3], pac1_r [3];
  logic                  vld1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      paa_nxt[i] = a_in[i] * a_in[i];
      pab_nxt[i] = a_in[i] * b_in[i];
      pac_nxt[i] = a_in[i] * c_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1_r[i]   <= a_in[i];
        b1_r[i]   <= b_in[i];
        c1_r[i]   <= c_in[i];
        paa1_r[i] <= paa_nxt[i][30:0];
        pab1_r[i] <= pab_nxt[i];
        pac1_r[i] <= pac_nxt[i];
      end
    end
  end

  // ---------------- stage 2: dot products with a ----------------
  logic signed [A_W-1:0] a2_r [3], b2_r [3], c2_r [3];
  logic [31:0]           aa_nxt, aa2_r;
  logic signed [32:0]    ab_nxt, ac_nxt, ab2_r, ac2_r;
  logic                  vld2_r;

  always_comb begin
    aa_nxt = 32'(paa1_r[0]) + 32'(paa1_r[1]) + 32'(paa1_r[2]);
    ab_nxt = 33'(pab1_r[0]) + 33'(pab1_r[1]) + 33'(pab1_r[2]);
    ac_nxt = 33'(pac1_r[0]) + 33'(pac1_r[1]) + 33'(pac1_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      c2_r  <= c1_r;
      aa2_r <= aa_nxt;
      ab2_r <= ab_nxt;
      ac2_r <= ac_nxt;
    end
  end

  // ---------------- stage 3: numerator magnitudes for proj on a ----------------
  logic [31:0]          ab_mag, ac_mag;
  logic [A_W-1:0]       a_mag [3];
  logic [47:0]          nab_nxt [3], nac_nxt [3], nab3_r [3], nac3_r [3];
  logic [2:0]           negab_nxt, negac_nxt, negab3_r, negac3_r;
  logic [31:0]          aa3_r;
  gs3_pkg::gs3_side_a_t side_a_nxt, side_a3_r;
  logic                 vld3_r;

  always_comb begin
    ab_mag = ab2_r[32] ? 32'(-ab2_r) : 32'(ab2_r);
    ac_mag = ac2_r[32] ? 32'(-ac2_r) : 32'(ac2_r);
    for (int i = 0; i < 3; i++) begin
      a_mag[i]     = a2_r[i][A_W-1] ? A_W'(-a2_r[i]) : a2_r[i];
      nab_nxt[i]   = 48'(ab_mag) * 48'(a_mag[i]);
      nac_nxt[i]   = 48'(ac_mag) * 48'(a_mag[i]);
      negab_nxt[i] = ab2_r[32] ^ a2_r[i][A_W-1];
      negac_nxt[i] = ac2_r[32] ^ a2_r[i][A_W-1];
      side_a_nxt.a[i] = a2_r[i];
      side_a_nxt.b[i] = b2_r[i];
      side_a_nxt.c[i] = c2_r[i];
    end
    side_a_nxt.degen = (aa2_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nab3_r    <= nab_nxt;
      nac3_r    <= nac_nxt;
      negab3_r  <= negab_nxt;
      negac3_r  <= negac_nxt;
      aa3_r     <= aa2_r;
      side_a3_r <= side_a_nxt;
    end
  end

  // ---------------- divider A: lanes 0-2 proj of b, 3-5 proj of c, on a --------
  logic [gs3_pkg::NUM1_W-1:0] div_a_num [6];
  logic signed [Q_W:0]        qa [6];
  gs3_pkg::gs3_side_a_t       side_a_out;
  logic                       div_a_vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_a_num[i]   = {nab3_r[i], 8'h00};
      div_a_num[3+i] = {nac3_r[i], 8'h00};
    end
  end

  gs3_div_pipe #(
    .LANES (6),
    .NW    (gs3_pkg::NUM1_W),
    .DW    (gs3_pkg::DEN1_W),
    .QW    (Q_W),
    .SW    ($bits(gs3_pkg::gs3_side_a_t))
  ) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld3_r),
    .in_num   (div_a_num),
    .in_neg   ({negac3_r, negab3_r}),
    .in_den   (aa3_r),
    .in_side  (side_a3_r),
    .out_vld  (div_a_vld),
    .out_quot (qa),
    .out_side (side_a_out)
  );

  // ---------------- stage 4: v2 and c minus its projection on a ----------------
  // |b*256| <= 2^23 and |proj| < 2^24, so neither difference needs saturation
  logic signed [V2_W-1:0] v2_nxt [3], t_nxt [3], v2_4_r [3], t4_r [3];
  logic signed [V2_W:0]   dv2 [3], dt [3];
  logic signed [23:0]     b_sh [3], c_sh [3];
  logic signed [A_W-1:0]  c4_r [3];
  logic [2:0][A_W-1:0]    a4_r;
  logic                   degen4_r, vld4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_sh[i]   = $signed({side_a_out.b[i], 8'h00});
      c_sh[i]   = $signed({side_a_out.c[i], 8'h00});
      dv2[i]    = b_sh[i] - qa[i];
      dt[i]     = c_sh[i] - qa[3+i];
      v2_nxt[i] = dv2[i][V2_W-1:0];
      t_nxt[i]  = dt[i][V2_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_4_r   <= v2_nxt;
      t4_r     <= t_nxt;
      for (int i = 0; i < 3; i++) begin
        c4_r[i] <= $signed(side_a_out.c[i]);
      end
      a4_r     <= side_a_out.a;
      degen4_r <= side_a_out.degen;
    end
  end

  // ---------------- stage 5: products for v2.v2 and v2.c ----------------
  logic signed [2*V2_W-1:0]       pvv_nxt [3];
  logic signed [V2_W+A_W-1:0]     pvc_nxt [3];
  logic [2*V2_W-3:0]              pvv5_r [3];
  logic signed [V2_W+A_W-2:0]     pvc5_r [3];
  logic signed [V2_W-1:0]         v2_5_r [3], t5_r [3];
  logic [2:0][A_W-1:0]            a5_r;
  logic                           degen5_r, vld5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pvv_nxt[i] = v2_4_r[i] * v2_4_r[i];
      pvc_nxt[i] = v2_4_r[i] * c4_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pvv5_r[i] <= pvv_nxt[i][2*V2_W-3:0];
        pvc5_r[i] <= pvc_nxt[i][V2_W+A_W-2:0];
      end
      v2_5_r   <= v2_4_r;
      t5_r     <= t4_r;
      a5_r     <= a4_r;
      degen5_r <= degen4_r;
    end
  end

  // ---------------- stage 6: v2.v2 and v2.c ----------------
  logic [gs3_pkg::DEN2_W-1:0]     vv_nxt, vv6_r;
  logic signed [gs3_pkg::VC_W-1:0] vc_nxt, vc6_r;
  logic signed [V2_W-1:0]         v2_6_r [3], t6_r [3];
  logic [2:0][A_W-1:0]            a6_r;
  logic                           degen6_r, vld6_r;

  always_comb begin
    vv_nxt = gs3_pkg::DEN2_W'(pvv5_r[0]) + gs3_pkg::DEN2_W'(pvv5_r[1])
           + gs3_pkg::DEN2_W'(pvv5_r[2]);
    vc_nxt = gs3_pkg::VC_W'(pvc5_r[0]) + gs3_pkg::VC_W'(pvc5_r[1])
           + gs3_pkg::VC_W'(pvc5_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vv6_r    <= vv_nxt;
      vc6_r    <= vc_nxt;
      v2_6_r   <= v2_5_r;
      t6_r     <= t5_r;
      a6_r     <= a5_r;
      degen6_r <= degen5_r;
    end
  end

  // ---------------- stage 7: numerator magnitudes for proj on v2 ----------------
  logic [gs3_pkg::VC_W-2:0]   vc_mag;
  logic [V2_W-2:0]            v2_mag [3];
  logic [gs3_pkg::NUM2_W-9:0] nvc_nxt [3], nvc7_r [3];
  logic [2:0]                 negvc_nxt, negvc7_r;
  logic [gs3_pkg::DEN2_W-1:0] vv7_r;
  gs3_pkg::gs3_side_b_t       side_b_nxt, side_b7_r;
  logic                       vld7_r;

  always_comb begin
    vc_mag = vc6_r[gs3_pkg::VC_W-1] ? (gs3_pkg::VC_W-1)'(-vc6_r)
                                    : (gs3_pkg::VC_W-1)'(vc6_r);
    for (int i = 0; i < 3; i++) begin
      v2_mag[i]    = v2_6_r[i][V2_W-1] ? (V2_W-1)'(-v2_6_r[i]) : (V2_W-1)'(v2_6_r[i]);
      nvc_nxt[i]   = (gs3_pkg::NUM2_W-8)'(vc_mag) * (gs3_pkg::NUM2_W-8)'(v2_mag[i]);
      negvc_nxt[i] = vc6_r[gs3_pkg::VC_W-1] ^ v2_6_r[i][V2_W-1];
      side_b_nxt.v2[i] = v2_6_r[i];
      side_b_nxt.t[i]  = t6_r[i];
    end
    side_b_nxt.a     = a6_r;
    side_b_nxt.degen = degen6_r || (vv6_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nvc7_r    <= nvc_nxt;
      negvc7_r  <= negvc_nxt;
      vv7_r     <= vv6_r;
      side_b7_r <= side_b_nxt;
    end
  end

  // ---------------- divider B: projection of c on v2 ----------------
  logic [gs3_pkg::NUM2_W-1:0] div_b_num [3];
  logic signed [Q_W:0]        qb [3];
  gs3_pkg::gs3_side_b_t       side_b_out;
  logic                       div_b_vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_b_num[i] = {nvc7_r[i], 8'h00};
    end
  end

  gs3_div_pipe #(
    .LANES (3),
    .NW    (gs3_pkg::NUM2_W),
    .DW    (gs3_pkg::DEN2_W),
    .QW    (Q_W),
    .SW    ($bits(gs3_pkg::gs3_side_b_t))
  ) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld7_r),
    .in_num   (div_b_num),
    .in_neg   (negvc7_r),
    .in_den   (vv7_r),
    .in_side  (side_b7_r),
    .out_vld  (div_b_vld),
    .out_quot (qb),
    .out_side (side_b_out)
  );

  // ---------------- stage 8: v3 and output register ----------------
  // |t| < 2^25 and |proj| < 2^24: v3 fits 27 bits, no saturation reached
  logic signed [V2_W:0]            v3_d [3];
  logic signed [gs3_pkg::OUT_W-1:0] first_nxt [3], second_nxt [3], third_nxt [3];
  logic signed [gs3_pkg::OUT_W-1:0] first_r [3], second_r [3], third_r [3];
  logic                            degen_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v3_d[i]       = $signed(side_b_out.t[i]) - qb[i];
      first_nxt[i]  = gs3_pkg::OUT_W'($signed({side_b_out.a[i], 8'h00}));
      second_nxt[i] = gs3_pkg::OUT_W'($signed(side_b_out.v2[i]));
      third_nxt[i]  = gs3_pkg::OUT_W'(v3_d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      third_r  <= third_nxt;
      degen_r  <= side_b_out.degen;
    end
  end

  // ---------------- valid bits of the top-level stages ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      vld4_r    <= 1'b0;
      vld5_r    <= 1'b0;
      vld6_r    <= 1'b0;
      vld7_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld1_r    <= in_chan.valid;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      vld4_r    <= div_a_vld;
      vld5_r    <= vld4_r;
      vld6_r    <= vld5_r;
      vld7_r    <= vld6_r;
      out_vld_r <= div_b_vld;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.first_x    = first_r[0];
  assign out_chan.first_y    = first_r[1];
  assign out_chan.first_z    = first_r[2];
  assign out_chan.second_x   = second_r[0];
  assign out_chan.second_y   = second_r[1];
  assign out_chan.second_z   = second_r[2];
  assign out_chan.third_x    = third_r[0];
  assign out_chan.third_y    = third_r[1];
  assign out_chan.third_z    = third_r[2];
  assign out_chan.degenerate = degen_r;

  a_zero_a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.first_x == '0 && out_chan.first_y == '0
     && out_chan.first_z == '0) |-> out_chan.degenerate)
    else $error("zero first vector without degenerate flag");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=>
      (out_chan.valid && $stable(out_chan.third_x) && $stable(out_chan.degenerate)))
    else $error("result changed while waiting");

endmodule

### dv/gram_schmidt_orthogonalize_3x3_test.sv
// Self-checking test for gram_schmidt_orthogonalize_3x3: random and corner vector triples,
// predicted in 128-bit arithmetic and compared field by field.
// Depends on gs3_pkg, gs3_in_if, gs3_out_if and the top level.
`timescale 1ns / 100ps

module gram_schmidt_orthogonalize_3x3_test;

  typedef logic signed [gs3_pkg::A_W-1:0] comp_t;
  typedef logic signed [gs3_pkg::OUT_W-1:0] res_t;

  typedef struct {
    comp_t a[3];
    comp_t b[3];
    comp_t c[3];
  } triple_t;

  typedef struct {
    res_t first[3];
    res_t second[3];
    res_t third[3];
    logic degenerate;
  } basis_t;

  localparam int LATENCY = 58;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic signed [127:0] PROJ_CLAMP = 128'sd1 <<< 62;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gs3_in_if  in_chan ();
  gs3_out_if out_chan ();

  gram_schmidt_orthogonalize_3x3 u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  triple_t pending_triples[$];
  basis_t  expected_bases[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      quiet_phase = 1'b0;
  bit      hold_sender = 1'b0;
  bit      long_hold_off = 1'b0;
  int      send_gap = 0;
  int      recv_gap = 0;
  int      accepted = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void queue_triple(triple_t t);
    pending_triples.insert(pending_triples.size(), t);
  endfunction

  function automatic void queue_basis(basis_t r);
    expected_bases.insert(expected_bases.size(), r);
  endfunction

  function automatic logic signed [127:0] sat_to_out(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  // trunc(x*y/d), magnitude clamped; zero when the denominator is zero
  function automatic logic signed [127:0] project(logic signed [127:0] x,
                                                   logic signed [127:0] y,
                                                   logic signed [127:0] d);
    logic signed [127:0] q;
    if (d == 0) return 0;
    q = (x * y) / d;
    if (q > PROJ_CLAMP) q = PROJ_CLAMP;
    if (q < -PROJ_CLAMP) q = -PROJ_CLAMP;
    return q;
  endfunction

  function automatic basis_t orthogonalize(triple_t t);
    basis_t r;
    logic signed [127:0] a[3], b[3], c[3], v2[3];
    logic signed [127:0] aa, ab, ac, v2v2, v2c;
    aa = 0; ab = 0; ac = 0; v2v2 = 0; v2c = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = t.a[i]; b[i] = t.b[i]; c[i] = t.c[i];
      aa += a[i] * a[i];
      ab += a[i] * b[i];
      ac += a[i] * c[i];
    end
    for (int i = 0; i < 3; i++)
      v2[i] = sat_to_out(b[i] * 256 - project(ab, a[i] * 256, aa));
    for (int i = 0; i < 3; i++) begin
      v2v2 += v2[i] * v2[i];
      v2c += v2[i] * c[i];
    end
    for (int i = 0; i < 3; i++) begin
      r.first[i] = res_t'(a[i] * 256);
      r.second[i] = res_t'(v2[i]);
      r.third[i] = res_t'(sat_to_out(c[i] * 256 - project(ac, a[i] * 256, aa)
                                     - project(v2c, v2[i] * 256, v2v2)));
    end
    r.degenerate = (aa == 0) || (v2v2 == 0);
    return r;
  endfunction

  function automatic comp_t rand_comp(int mode);
    unique case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(0, 64)) - comp_t'(32);
      2: return ($urandom_range(0, 1) != 0) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
      default: return comp_t'($urandom_range(0, 2047)) - comp_t'(1024);
    endcase
  endfunction

  function automatic triple_t rand_triple();
    triple_t t;
    int mode;
    int shape;
    mode = $urandom_range(0, 5);
    if (mode > 3) mode = 0;
    for (int i = 0; i < 3; i++) begin
      t.a[i] = rand_comp(mode);
      t.b[i] = rand_comp(mode);
      t.c[i] = rand_comp(mode);
    end
    shape = $urandom_range(0, 19);
    // sprinkle zero a, b parallel to a, c equal to b, and zero components of a
    if (shape == 0) t.a = '{0, 0, 0};
    else if (shape == 1) t.b = t.a;
    else if (shape == 2) for (int i = 0; i < 3; i++) t.b[i] = -t.a[i];
    else if (shape == 3) t.c = t.b;
    else if (shape == 4) t.a[$urandom_range(0, 2)] = 0;
    return t;
  endfunction

  function automatic triple_t make_triple(comp_t ax, comp_t ay, comp_t az,
                                          comp_t bx, comp_t by, comp_t bz,
                                          comp_t cx, comp_t cy, comp_t cz);
    triple_t t;
    t.a = '{ax, ay, az};
    t.b = '{bx, by, bz};
    t.c = '{cx, cy, cz};
    return t;
  endfunction

  initial begin
    comp_t mx, mn;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    queue_triple(make_triple(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_triple(make_triple(0, 0, 0, 256, 0, 0, 0, 256, 0));
    queue_triple(make_triple(256, 0, 0, 512, 0, 0, 0, 0, 256));
    queue_triple(make_triple(256, 0, 0, 0, 256, 0, 0, 0, 256));
    queue_triple(make_triple(256, 256, 0, 256, 0, 0, 77, -99, 300));
    queue_triple(make_triple(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    queue_triple(make_triple(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    queue_triple(make_triple(mx, mn, mx, mn, mx, mn, mx, mn, mx));
    queue_triple(make_triple(1, 0, 0, mx, mn, mx, mn, mx, mn));
    queue_triple(make_triple(1, 1, 1, -1, 0, 1, mx, mx, mn));
    queue_triple(make_triple(mn, 0, 0, 0, mx, 0, 0, 0, mn));
    queue_triple(make_triple(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    queue_triple(make_triple(3, 7, -5, 1, 2, 3, 4, 5, 6));
    queue_triple(make_triple(0, 0, 1, mn, mn, 1, mx, 0, -1));
    for (int n = 0; n < 1400; n++) queue_triple(rand_triple());
  end

  // request driver
  always @(posedge clk) begin
    int room;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        queue_basis(orthogonalize(pending_triples.pop_front()));
        accepted <= accepted + 1;
      end
      room = !in_chan.valid || in_chan.ready;
      if (room) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_chan.valid <= 1'b0;
        end else if (hold_sender || pending_triples.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 9) - 1;
          in_chan.valid <= 1'b0;
        end else begin
          in_chan.valid <= 1'b1;
          in_chan.a_x <= pending_triples[0].a[0];
          in_chan.a_y <= pending_triples[0].a[1];
          in_chan.a_z <= pending_triples[0].a[2];
          in_chan.b_x <= pending_triples[0].b[0];
          in_chan.b_y <= pending_triples[0].b[1];
          in_chan.b_z <= pending_triples[0].b[2];
          in_chan.c_x <= pending_triples[0].c[0];
          in_chan.c_y <= pending_triples[0].c[1];
          in_chan.c_z <= pending_triples[0].c[2];
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    basis_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_bases.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_bases.pop_front();
          if (out_chan.first_x !== want.first[0]) begin
            $error("first_x exp %0d got %0d", want.first[0], out_chan.first_x); error_count++;
          end
          if (out_chan.first_y !== want.first[1]) begin
            $error("first_y exp %0d got %0d", want.first[1], out_chan.first_y); error_count++;
          end
          if (out_chan.first_z !== want.first[2]) begin
            $error("first_z exp %0d got %0d", want.first[2], out_chan.first_z); error_count++;
          end
          if (out_chan.second_x !== want.second[0]) begin
            $error("second_x exp %0d got %0d", want.second[0], out_chan.second_x);
            error_count++;
          end
          if (out_chan.second_y !== want.second[1]) begin
            $error("second_y exp %0d got %0d", want.second[1], out_chan.second_y);
            error_count++;
          end
          if (out_chan.second_z !== want.second[2]) begin
            $error("second_z exp %0d got %0d", want.second[2], out_chan.second_z);
            error_count++;
          end
          if (out_chan.third_x !== want.third[0]) begin
            $error("third_x exp %0d got %0d", want.third[0], out_chan.third_x); error_count++;
          end
          if (out_chan.third_y !== want.third[1]) begin
            $error("third_y exp %0d got %0d", want.third[1], out_chan.third_y); error_count++;
          end
          if (out_chan.third_z !== want.third[2]) begin
            $error("third_z exp %0d got %0d", want.third[2], out_chan.third_z); error_count++;
          end
          if (out_chan.degenerate !== want.degenerate) begin
            $error("degenerate exp %0b got %0b", want.degenerate, out_chan.degenerate);
            error_count++;
          end
        end
      end
      if (long_hold_off || recv_gap > 0) begin
        if (recv_gap > 0) recv_gap <= recv_gap - 1;
        out_chan.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 9) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // long receiver hold-off while requests keep coming, so the pipe fills
    wait (accepted >= 200);
    @(posedge clk);
    long_hold_off <= 1'b1;
    for (int n = 0; n < 150; n++) @(posedge clk);
    long_hold_off <= 1'b0;
    // sender pauses until the pipe drains
    wait (accepted >= 600);
    @(posedge clk);
    hold_sender <= 1'b1;
    wait (expected_bases.size() == 0);
    @(posedge clk);
    hold_sender <= 1'b0;
    wait (pending_triples.size() < 200);
    @(posedge clk);
    quiet_phase <= 1'b1;
    wait (pending_triples.size() == 0 && !(in_chan.valid && !in_chan.ready));
    @(posedge clk);
    wait (expected_bases.size() == 0);
    for (int n = 0; n < LATENCY + 10; n++) @(posedge clk);
    if (error_count == 0 && expected_bases.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
